// File: rtl/core/ddn_pkg.sv
// ----------------------------------------------------------------------------
// Detection decode package
// Shared types, reset values and sizes for the decode and suppression block.
// ----------------------------------------------------------------------------
package ddn_pkg;

   localparam int MaxKeptDefault     = 64;
   localparam int MaxChannelsDefault = 128;
   localparam int QueueDepth         = 4;

   localparam logic [14:0] ScoreThresholdReset   = 15'd22938;
   localparam logic [15:0] OverlapThresholdReset = 16'd32768;
   localparam logic [7:0]  ChannelCountReset     = 8'd84;
   localparam logic [7:0]  MinChannels           = 8'd5;

   localparam logic [7:0] RegScoreThreshold   = 8'd0;
   localparam logic [7:0] RegOverlapThreshold = 8'd1;
   localparam logic [7:0] RegChannelCount     = 8'd2;

   typedef struct packed {
      logic signed [11:0] left;
      logic signed [11:0] top;
      logic [10:0]        width;
      logic [10:0]        height;
      logic [14:0]        score;
      logic [6:0]         channel;
   } ddn_entry_type;

   typedef struct packed {
      logic          cand;
      logic          fend;
      ddn_entry_type entry;
   } ddn_item_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_PLACE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRITE_NEW,
      ST_AFTER,
      ST_NMS_START,
      ST_NMS_RDI,
      ST_NMS_LDI,
      ST_NMS_NEXTJ,
      ST_NMS_A,
      ST_NMS_B,
      ST_NMS_C,
      ST_NMS_D,
      ST_NMS_NEXTI,
      ST_EMIT_START,
      ST_EMIT_SCAN,
      ST_EMIT_OUT,
      ST_EMIT_EMPTY
   } ddn_state_type;

endpackage

// File: rtl/core/ddn_req_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Carries one tensor value per beat with its channel tag and frame marker.
// ----------------------------------------------------------------------------
interface ddn_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_value;
   logic [6:0]         channel_index;
   logic               frame_end;

   modport source(output valid, sample_value, channel_index, frame_end, input ready);
   modport sink(input valid, sample_value, channel_index, frame_end, output ready);
endinterface

// File: rtl/core/ddn_rsp_if.sv
// ----------------------------------------------------------------------------
// Detection channel
// Carries one surviving detection per beat.
// ----------------------------------------------------------------------------
interface ddn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [11:0] box_left;
   logic signed [11:0] box_top;
   logic [10:0]        box_width;
   logic [10:0]        box_height;
   logic [14:0]        box_score;
   logic [6:0]         class_channel;
   logic               detection_valid;
   logic               store_overflowed;
   logic               last_detection;

   modport source(output valid, box_left, box_top, box_width, box_height, box_score,
                  class_channel, detection_valid, store_overflowed, last_detection,
                  input ready);
   modport sink(input valid, box_left, box_top, box_width, box_height, box_score,
                class_channel, detection_valid, store_overflowed, last_detection,
                output ready);
endinterface

// File: rtl/core/ddn_csr_if.sv
// ----------------------------------------------------------------------------
// Register write channel
// Carries one register index and its write data per beat.
// ----------------------------------------------------------------------------
interface ddn_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/core/ddn_front.sv
// ----------------------------------------------------------------------------
// Anchor front end
// Collects box and best score per anchor and queues candidates and frame ends.
// ----------------------------------------------------------------------------
module ddn_front #(
   parameter int MAX_CHANNELS = ddn_pkg::MaxChannelsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   ddn_req_if.sink               req_chan,
   input  logic [14:0]           score_threshold,
   input  logic [7:0]            channel_count,
   output logic                  push_valid,
   input  logic                  push_ready,
   output ddn_pkg::ddn_item_type push_item
);
   import ddn_pkg::*;

   logic signed [15:0] box_ff [4];
   logic signed [15:0] box_in [4];
   logic signed [15:0] best_ff, best_in;
   logic [6:0]         chan_ff, chan_in;
   logic [7:0]         cc_eff;
   logic               accept, done;
   logic signed [17:0] vx, vy, tx, ty;
   logic signed [12:0] qx, qy;

   function automatic logic signed [11:0] clamp12(input logic signed [12:0] v);
      if (v > 13'sd2047) begin
         return 12'sd2047;
      end else if (v < -13'sd2048) begin
         return -12'sd2048;
      end
      return v[11:0];
   endfunction

   always_comb begin
      if (channel_count < MinChannels) begin
         cc_eff = MinChannels;
      end else if (channel_count > 8'(MAX_CHANNELS)) begin
         cc_eff = 8'(MAX_CHANNELS);
      end else begin
         cc_eff = channel_count;
      end
   end

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && push_ready;
   assign done = ({1'b0, req_chan.channel_index} == cc_eff - 8'd1) || req_chan.frame_end;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         box_in[k] = box_ff[k];
      end
      best_in = best_ff;
      chan_in = chan_ff;
      if ({1'b0, req_chan.channel_index} < cc_eff) begin
         if (req_chan.channel_index < 7'd4) begin
            box_in[req_chan.channel_index[1:0]] = req_chan.sample_value;
         end else if (req_chan.sample_value > best_ff) begin
            best_in = req_chan.sample_value;
            chan_in = req_chan.channel_index;
         end
      end
   end

   always_comb begin
      vx = {{1{box_in[0][15]}}, box_in[0], 1'b0} - 18'(box_in[2]);
      vy = {{1{box_in[1][15]}}, box_in[1], 1'b0} - 18'(box_in[3]);
      tx = vx + (vx[17] ? 18'sd31 : 18'sd0);
      ty = vy + (vy[17] ? 18'sd31 : 18'sd0);
      qx = 13'(tx >>> 5);
      qy = 13'(ty >>> 5);
      push_item.cand = best_in > $signed({1'b0, score_threshold});
      push_item.fend = req_chan.frame_end;
      push_item.entry.left = clamp12(qx);
      push_item.entry.top = clamp12(qy);
      push_item.entry.width = box_in[2][15] ? 11'd0 : box_in[2][14:4];
      push_item.entry.height = box_in[3][15] ? 11'd0 : box_in[3][14:4];
      push_item.entry.score = best_in[14:0];
      push_item.entry.channel = chan_in;
      push_valid = req_chan.valid && done && (push_item.cand || req_chan.frame_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            box_ff[k] <= '0;
         end
         best_ff <= -16'sd32768;
         chan_ff <= '0;
      end else if (accept) begin
         if (done) begin
            for (int k = 0; k < 4; k++) begin
               box_ff[k] <= '0;
            end
            best_ff <= -16'sd32768;
            chan_ff <= '0;
         end else begin
            box_ff <= box_in;
            best_ff <= best_in;
            chan_ff <= chan_in;
         end
      end
   end

endmodule

// File: rtl/core/ddn_queue.sv
// ----------------------------------------------------------------------------
// Candidate queue
// Short first-in first-out buffer between the front end and the store.
// ----------------------------------------------------------------------------
module ddn_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  ddn_pkg::ddn_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output ddn_pkg::ddn_item_type pop_item
);
   import ddn_pkg::*;

   localparam int PW = $clog2(QueueDepth);

   ddn_item_type    mem_ff [QueueDepth];
   logic [PW:0]     wr_ptr_ff, rd_ptr_ff;

   assign push_ready = (wr_ptr_ff - rd_ptr_ff) != (PW + 1)'(QueueDepth);
   assign pop_valid = wr_ptr_ff != rd_ptr_ff;
   assign pop_item = mem_ff[rd_ptr_ff[PW-1:0]];

   always_ff @(posedge clock) begin
      if (push_valid && push_ready) begin
         mem_ff[wr_ptr_ff[PW-1:0]] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push_valid && push_ready) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_valid && pop_ready) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// File: rtl/core/ddn_back.sv
// ----------------------------------------------------------------------------
// Store and suppression back end
// Keeps the score-sorted store, runs greedy overlap suppression at frame end
// and sends the surviving detections.
// ----------------------------------------------------------------------------
module ddn_back #(
   parameter int MAX_KEPT = ddn_pkg::MaxKeptDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  ddn_pkg::ddn_item_type pop_item,
   input  logic [15:0]           overlap_threshold,
   ddn_rsp_if.source             rsp_chan
);
   import ddn_pkg::*;

   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

   ddn_state_type state_ff, state_in;
   ddn_entry_type mem [MAX_KEPT];
   ddn_entry_type mem_q_ff;
   ddn_item_type  item_ff;
   ddn_entry_type boxi_ff;

   logic [CW-1:0] count_ff, pos_ff, idx_ff, i_ff, j_ff;
   logic [IW-1:0] last_ff, rd_addr, wr_addr;
   logic          ovf_ff, surv_any_ff;
   logic [MAX_KEPT-1:0] marks_ff;
   logic          rd_en, wr_en, out_free, out_load;
   ddn_entry_type wr_data;

   logic [21:0]        aa_ff, ab_ff;
   logic [12:0]        dx_ff, dy_ff;
   logic               hit_ff, zero_ff;
   logic [25:0]        inter_ff;
   logic [41:0]        lhs_ff;
   logic [38:0]        rhs_ff;
   logic [22:0]        uni;
   logic signed [11:0] x1, y1;
   logic signed [12:0] x2, y2, ra, rb, ba, bb;
   logic signed [13:0] ddx, ddy;

   logic               out_valid_ff, out_dvalid_ff, out_ovf_ff, out_last_ff;
   ddn_entry_type      out_entry_ff;

   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               if (pop_item.cand) begin
                  state_in = (count_ff != '0) ? ST_SCAN_RD : ST_PLACE;
               end else begin
                  state_in = ST_NMS_START;
               end
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (mem_q_ff.score >= item_ff.entry.score && pos_ff + 1'b1 < count_ff) begin
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (count_ff >= CW'(MAX_KEPT)) begin
               if (pos_ff >= CW'(MAX_KEPT)) begin
                  state_in = ST_AFTER;
               end else if (CW'(MAX_KEPT - 1) > pos_ff) begin
                  state_in = ST_SHIFT_RD;
               end else begin
                  state_in = ST_WRITE_NEW;
               end
            end else begin
               state_in = (count_ff > pos_ff) ? ST_SHIFT_RD : ST_WRITE_NEW;
            end
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: state_in = (idx_ff - 1'b1 > pos_ff) ? ST_SHIFT_RD : ST_WRITE_NEW;
         ST_WRITE_NEW: state_in = ST_AFTER;
         ST_AFTER: state_in = item_ff.fend ? ST_NMS_START : ST_IDLE;
         ST_NMS_START: state_in = (count_ff == '0) ? ST_EMIT_START : ST_NMS_RDI;
         ST_NMS_RDI: state_in = ST_NMS_LDI;
         ST_NMS_LDI: state_in = ST_NMS_NEXTJ;
         ST_NMS_NEXTJ: begin
            if (j_ff == i_ff) begin
               state_in = ST_NMS_NEXTI;
            end else if (!marks_ff[j_ff[IW-1:0]]) begin
               state_in = ST_NMS_A;
            end
         end
         ST_NMS_A: state_in = ST_NMS_B;
         ST_NMS_B: state_in = ST_NMS_C;
         ST_NMS_C: state_in = ST_NMS_D;
         ST_NMS_D: begin
            if (zero_ff || lhs_ff > 42'(rhs_ff)) begin
               state_in = ST_NMS_NEXTI;
            end else begin
               state_in = ST_NMS_NEXTJ;
            end
         end
         ST_NMS_NEXTI: state_in = (i_ff + 1'b1 < count_ff) ? ST_NMS_RDI : ST_EMIT_START;
         ST_EMIT_START: state_in = surv_any_ff ? ST_EMIT_SCAN : ST_EMIT_EMPTY;
         ST_EMIT_SCAN: begin
            if (!marks_ff[i_ff[IW-1:0]]) begin
               state_in = ST_EMIT_OUT;
            end
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               state_in = (i_ff[IW-1:0] == last_ff) ? ST_IDLE : ST_EMIT_SCAN;
            end
         end
         ST_EMIT_EMPTY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = 1'b0;
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = mem_q_ff;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: pop_ready = 1'b1;
         ST_SCAN_RD: begin
            rd_en = 1'b1;
            rd_addr = pos_ff[IW-1:0];
         end
         ST_SHIFT_RD: begin
            rd_en = 1'b1;
            rd_addr = IW'(idx_ff - 1'b1);
         end
         ST_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_addr = idx_ff[IW-1:0];
         end
         ST_WRITE_NEW: begin
            wr_en = 1'b1;
            wr_addr = pos_ff[IW-1:0];
            wr_data = item_ff.entry;
         end
         ST_NMS_RDI: begin
            rd_en = 1'b1;
            rd_addr = i_ff[IW-1:0];
         end
         ST_NMS_NEXTJ: begin
            rd_en = (j_ff != i_ff) && !marks_ff[j_ff[IW-1:0]];
            rd_addr = j_ff[IW-1:0];
         end
         ST_EMIT_SCAN: begin
            rd_en = !marks_ff[i_ff[IW-1:0]];
            rd_addr = i_ff[IW-1:0];
         end
         ST_EMIT_OUT: out_load = out_free;
         ST_EMIT_EMPTY: out_load = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      ra = 13'(boxi_ff.left) + 13'($signed({1'b0, boxi_ff.width}));
      rb = 13'(mem_q_ff.left) + 13'($signed({1'b0, mem_q_ff.width}));
      ba = 13'(boxi_ff.top) + 13'($signed({1'b0, boxi_ff.height}));
      bb = 13'(mem_q_ff.top) + 13'($signed({1'b0, mem_q_ff.height}));
      x1 = (boxi_ff.left > mem_q_ff.left) ? boxi_ff.left : mem_q_ff.left;
      y1 = (boxi_ff.top > mem_q_ff.top) ? boxi_ff.top : mem_q_ff.top;
      x2 = (ra < rb) ? ra : rb;
      y2 = (ba < bb) ? ba : bb;
      ddx = 14'(x2) - 14'(x1);
      ddy = 14'(y2) - 14'(y1);
      uni = 23'(aa_ff) + 23'(ab_ff) - 23'(inter_ff);
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            item_ff <= pop_item;
            pos_ff <= '0;
         end
         ST_SCAN_CHK: begin
            if (mem_q_ff.score >= item_ff.entry.score) begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
         ST_PLACE: begin
            idx_ff <= (count_ff >= CW'(MAX_KEPT)) ? CW'(MAX_KEPT - 1) : count_ff;
         end
         ST_SHIFT_WR: idx_ff <= idx_ff - 1'b1;
         ST_NMS_START: i_ff <= '0;
         ST_NMS_LDI: begin
            boxi_ff <= mem_q_ff;
            j_ff <= '0;
         end
         ST_NMS_NEXTJ: begin
            if (j_ff != i_ff && marks_ff[j_ff[IW-1:0]]) begin
               j_ff <= j_ff + 1'b1;
            end
         end
         ST_NMS_A: begin
            aa_ff <= boxi_ff.width * boxi_ff.height;
            ab_ff <= mem_q_ff.width * mem_q_ff.height;
            dx_ff <= ddx[12:0];
            dy_ff <= ddy[12:0];
            hit_ff <= (ddx > 14'sd0) && (ddy > 14'sd0);
            zero_ff <= (boxi_ff.width == '0 || boxi_ff.height == '0) &&
                       (mem_q_ff.width == '0 || mem_q_ff.height == '0);
         end
         ST_NMS_B: inter_ff <= hit_ff ? dx_ff * dy_ff : '0;
         ST_NMS_C: begin
            lhs_ff <= {inter_ff, 16'd0};
            rhs_ff <= overlap_threshold * uni;
         end
         ST_NMS_D: j_ff <= j_ff + 1'b1;
         ST_NMS_NEXTI: i_ff <= i_ff + 1'b1;
         ST_EMIT_START: i_ff <= '0;
         ST_EMIT_SCAN: begin
            if (marks_ff[i_ff[IW-1:0]]) begin
               i_ff <= i_ff + 1'b1;
            end
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               i_ff <= i_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         marks_ff <= '0;
         surv_any_ff <= 1'b0;
         last_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_PLACE: begin
               if (count_ff >= CW'(MAX_KEPT)) begin
                  ovf_ff <= 1'b1;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            ST_NMS_START: surv_any_ff <= 1'b0;
            ST_NMS_NEXTJ: begin
               if (j_ff == i_ff) begin
                  surv_any_ff <= 1'b1;
                  last_ff <= i_ff[IW-1:0];
               end
            end
            ST_NMS_D: begin
               if (zero_ff || lhs_ff > 42'(rhs_ff)) begin
                  marks_ff[i_ff[IW-1:0]] <= 1'b1;
               end
            end
            ST_EMIT_OUT, ST_EMIT_EMPTY: begin
               if (out_free && (state_ff == ST_EMIT_EMPTY || i_ff[IW-1:0] == last_ff)) begin
                  count_ff <= '0;
                  ovf_ff <= 1'b0;
                  marks_ff <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ovf_ff <= ovf_ff;
         if (state_ff == ST_EMIT_EMPTY) begin
            out_entry_ff <= '0;
            out_dvalid_ff <= 1'b0;
            out_last_ff <= 1'b1;
         end else begin
            out_entry_ff <= mem_q_ff;
            out_dvalid_ff <= 1'b1;
            out_last_ff <= i_ff[IW-1:0] == last_ff;
         end
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.box_left = out_entry_ff.left;
   assign rsp_chan.box_top = out_entry_ff.top;
   assign rsp_chan.box_width = out_entry_ff.width;
   assign rsp_chan.box_height = out_entry_ff.height;
   assign rsp_chan.box_score = out_entry_ff.score;
   assign rsp_chan.class_channel = out_entry_ff.channel;
   assign rsp_chan.detection_valid = out_dvalid_ff;
   assign rsp_chan.store_overflowed = out_ovf_ff;
   assign rsp_chan.last_detection = out_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_KEPT))
      else $error("store count beyond capacity");

   a_marks_clear_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> marks_ff == '0)
      else $error("suppression marks left over after frame");

   a_last_clears_store: assert property (@(posedge clock) disable iff (reset)
      out_load && (state_ff == ST_EMIT_EMPTY || i_ff[IW-1:0] == last_ff) |=>
      count_ff == '0 && !ovf_ff)
      else $error("store not cleared after final detection");

endmodule

// File: rtl/core/detection_decode_nms.sv
// ----------------------------------------------------------------------------
// Detection decode with greedy suppression
// A candidate sorts into the store by scanning and shifting entries; at frame end
// suppression compares box pairs before the surviving detections leave.
// Throughput: one sample per cycle while the candidate queue has room.
// Reset: synchronous; registers return to defaults, the store is empty.
// ----------------------------------------------------------------------------
module detection_decode_nms #(
   parameter int MAX_KEPT     = ddn_pkg::MaxKeptDefault,
   parameter int MAX_CHANNELS = ddn_pkg::MaxChannelsDefault
) (
   input  logic     clock,
   input  logic     reset,
   ddn_req_if.sink  req_chan,
   ddn_rsp_if.source rsp_chan,
   ddn_csr_if.sink  csr_chan
);
   import ddn_pkg::*;

   logic [14:0]  score_thr_ff;
   logic [15:0]  overlap_thr_ff;
   logic [7:0]   chan_count_ff;
   logic         push_valid, push_ready, pop_valid, pop_ready;
   ddn_item_type push_item, pop_item;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         score_thr_ff <= ScoreThresholdReset;
         overlap_thr_ff <= OverlapThresholdReset;
         chan_count_ff <= ChannelCountReset;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            RegScoreThreshold: score_thr_ff <= csr_chan.data[14:0];
            RegOverlapThreshold: overlap_thr_ff <= csr_chan.data;
            RegChannelCount: chan_count_ff <= csr_chan.data[7:0];
            default: begin
            end
         endcase
      end
   end

   ddn_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .score_threshold(score_thr_ff),
      .channel_count(chan_count_ff),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item)
   );

   ddn_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item)
   );

   ddn_back #(.MAX_KEPT(MAX_KEPT)) u_back (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item),
      .overlap_threshold(overlap_thr_ff),
      .rsp_chan(rsp_chan)
   );

endmodule

// File: sim/tb_ifaces.sv
// ----------------------------------------------------------------------------
// Testbench channel interfaces
// The block's channel interfaces are used directly; this file keeps the
// testbench-only shared definitions in one place.
// ----------------------------------------------------------------------------
package tb_ddn_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] value;
      logic [6:0]         chan;
      logic               fend;
   } sample_beat_type;

   typedef struct packed {
      logic signed [11:0] left;
      logic signed [11:0] top;
      logic [10:0]        width;
      logic [10:0]        height;
      logic [14:0]        score;
      logic [6:0]         chan;
      logic               dvalid;
      logic               ovf;
      logic               last;
   } detection_type;
endpackage

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Detection decode testbench
// Streams tensor frames into the block, predicts the surviving detections
// with a behavioral decoder and greedy suppressor, and checks every beat.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ddn_pkg::*;
   import tb_ddn_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddn_req_if req_chan();
   ddn_rsp_if rsp_chan();
   ddn_csr_if csr_chan();

   detection_decode_nms DUT (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Predictor state.
   logic [14:0]        thr_score = ScoreThresholdReset;
   logic [15:0]        thr_overlap = OverlapThresholdReset;
   logic [7:0]         chan_count = ChannelCountReset;
   int                 cur_box[4];
   int                 best_val = -32768;
   int                 best_chan = 0;
   int                 kept_left[64], kept_top[64], kept_w[64], kept_h[64];
   int                 kept_score[64], kept_chan[64];
   bit                 kept_sup[64];
   int                 kept_count = 0;
   bit                 ovf_flag = 0;

   sample_beat_type    pending_beats[$];
   detection_type      expected_dets[$];
   int                 errors = 0;
   int                 frames = 0;
   int                 dets_seen = 0;
   bit                 hold_rsp = 0;
   bit                 hold_arm = 0;
   bit                 hold_used = 0;
   int                 hold_cnt = 0;
   bit                 req_fire = 0;

   function automatic int clampi(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int div_trunc(int a, int b);
      int q;
      q = (a < 0 ? -a : a) / b;
      return a < 0 ? -q : q;
   endfunction

   function automatic void store_candidate();
      int l, t, w, h, pos, i;
      l = clampi(div_trunc(2 * cur_box[0] - cur_box[2], 32), -2048, 2047);
      t = clampi(div_trunc(2 * cur_box[1] - cur_box[3], 32), -2048, 2047);
      w = clampi(div_trunc(cur_box[2], 16), 0, 2047);
      h = clampi(div_trunc(cur_box[3], 16), 0, 2047);
      pos = 0;
      while (pos < kept_count && kept_score[pos] >= best_val) pos++;
      if (kept_count >= 64) begin
         ovf_flag = 1;
         if (pos >= 64) return;
         i = 63;
      end else begin
         i = kept_count;
         kept_count++;
      end
      for (; i > pos; i--) begin
         kept_left[i] = kept_left[i-1]; kept_top[i] = kept_top[i-1];
         kept_w[i] = kept_w[i-1]; kept_h[i] = kept_h[i-1];
         kept_score[i] = kept_score[i-1]; kept_chan[i] = kept_chan[i-1];
      end
      kept_left[pos] = l; kept_top[pos] = t; kept_w[pos] = w; kept_h[pos] = h;
      kept_score[pos] = best_val; kept_chan[pos] = best_chan;
   endfunction

   function automatic bit too_close(int a, int b);
      longint aa, ab, inter, uni;
      int x1, x2, y1, y2;
      aa = longint'(kept_w[a]) * kept_h[a];
      ab = longint'(kept_w[b]) * kept_h[b];
      if (aa + ab == 0) return 1;
      x1 = kept_left[a] > kept_left[b] ? kept_left[a] : kept_left[b];
      x2 = (kept_left[a] + kept_w[a]) < (kept_left[b] + kept_w[b]) ?
           kept_left[a] + kept_w[a] : kept_left[b] + kept_w[b];
      y1 = kept_top[a] > kept_top[b] ? kept_top[a] : kept_top[b];
      y2 = (kept_top[a] + kept_h[a]) < (kept_top[b] + kept_h[b]) ?
           kept_top[a] + kept_h[a] : kept_top[b] + kept_h[b];
      inter = 0;
      if (x2 > x1 && y2 > y1) inter = longint'(x2 - x1) * (y2 - y1);
      uni = aa + ab - inter;
      return inter * 65536 > longint'(thr_overlap) * uni;
   endfunction

   function automatic void decode_sample(sample_beat_type s);
      int cc, sv, ch, n, i, j;
      detection_type d;
      cc = clampi(chan_count, 5, 128);
      sv = s.value;
      ch = s.chan;
      if (ch < cc) begin
         if (ch < 4) cur_box[ch] = sv;
         else if (sv > best_val) begin
            best_val = sv;
            best_chan = ch;
         end
      end
      if (ch == cc - 1 || s.fend) begin
         if (best_val > int'(thr_score)) store_candidate();
         cur_box = '{0, 0, 0, 0};
         best_val = -32768;
         best_chan = 0;
      end
      if (!s.fend) return;
      for (i = 0; i < kept_count; i++) begin
         kept_sup[i] = 0;
         for (j = 0; j < i; j++) begin
            if (!kept_sup[j] && too_close(j, i)) begin
               kept_sup[i] = 1;
               break;
            end
         end
      end
      n = 0;
      for (i = 0; i < kept_count; i++) begin
         if (!kept_sup[i]) begin
            d.left = kept_left[i]; d.top = kept_top[i];
            d.width = kept_w[i]; d.height = kept_h[i];
            d.score = kept_score[i]; d.chan = kept_chan[i];
            d.dvalid = 1; d.ovf = ovf_flag; d.last = 0;
            expected_dets.insert(expected_dets.size(), d);
            n++;
         end
      end
      if (n == 0) begin
         d = '{0, 0, 0, 0, 0, 0, 0, ovf_flag, 1};
         expected_dets.insert(expected_dets.size(), d);
      end else begin
         expected_dets[$].last = 1;
      end
      kept_count = 0;
      ovf_flag = 0;
      frames++;
   endfunction

   // Driver.
   int req_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_fire) begin
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_chan.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
         req_chan.valid <= 1'b1;
         req_chan.sample_value <= pending_beats[0].value;
         req_chan.channel_index <= pending_beats[0].chan;
         req_chan.frame_end <= pending_beats[0].fend;
         void'(pending_beats.pop_front());
         req_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                    (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
                     $urandom_range(1, 3));
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         sample_beat_type s;
         s.value = req_chan.sample_value;
         s.chan = req_chan.channel_index;
         s.fend = req_chan.frame_end;
         decode_sample(s);
      end
   end

   // Long receiver hold, started by the first detection once armed.
   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         if (hold_cnt == 1) hold_rsp <= 1'b0;
      end else if (hold_arm && !hold_used && rsp_chan.valid) begin
         hold_used <= 1'b1;
         hold_cnt <= 300;
         hold_rsp <= 1'b1;
      end
   end

   // Receiver.
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         rsp_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                    (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
                     $urandom_range(1, 3));
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         detection_type a, e;
         a = '{rsp_chan.box_left, rsp_chan.box_top, rsp_chan.box_width,
               rsp_chan.box_height, rsp_chan.box_score, rsp_chan.class_channel,
               rsp_chan.detection_valid, rsp_chan.store_overflowed,
               rsp_chan.last_detection};
         dets_seen++;
         if (expected_dets.size() == 0) begin
            $display("%0t: unexpected detection %p", $realtime, a);
            errors++;
         end else begin
            e = expected_dets.pop_front();
            if (a !== e) begin
               $display("%0t: mismatch expected %p actual %p", $realtime, e, a);
               errors++;
            end
         end
      end
   end

   task automatic write_reg(logic [7:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         RegScoreThreshold:   thr_score = val[14:0];
         RegOverlapThreshold: thr_overlap = val;
         RegChannelCount:     chan_count = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic push_beat(int v, int ch, bit fe);
      sample_beat_type s;
      s.value = 16'(v);
      s.chan = 7'(ch);
      s.fend = fe;
      pending_beats.insert(pending_beats.size(), s);
   endtask

   task automatic push_anchor(int cc, bit overlap_heavy, bit fe);
      int k, v;
      for (k = 0; k < cc; k++) begin
         if (k < 2) v = overlap_heavy ? $urandom_range(800, 1200) : $urandom_range(0, 65535);
         else if (k < 4) v = overlap_heavy ? $urandom_range(100, 900) : $urandom_range(0, 65535);
         else v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
                  $urandom_range(0, 32767);
         push_beat(v, k, fe && k == cc - 1);
      end
   endtask

   task automatic drain();
      int w;
      w = 0;
      while ((pending_beats.size() > 0 || req_chan.valid || expected_dets.size() > 0)
             && w < 200000) begin
         @(posedge clock);
         w++;
      end
      repeat (400) @(posedge clock);
   endtask

   initial begin
      int f, a, na, cc;
      req_chan.valid = 1'b0;
      req_chan.sample_value = '0;
      req_chan.channel_index = '0;
      req_chan.frame_end = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: small anchors, extremes, ties, missing channels, empty frame.
      write_reg(RegChannelCount, 16'd0);
      write_reg(RegScoreThreshold, 16'd0);
      write_reg(RegOverlapThreshold, 16'hFFFF);
      push_beat(16'sh7FFF, 0, 0); push_beat(-32768, 1, 0);
      push_beat(16'sh7FFF, 2, 0); push_beat(16'sh7FFF, 3, 0);
      push_beat(16'sh7FFF, 4, 0);
      push_beat(-32768, 0, 0); push_beat(16'sh7FFF, 1, 0);
      push_beat(-32768, 2, 0); push_beat(-32768, 3, 0);
      push_beat(100, 4, 0);
      push_beat(5, 127, 0);                 // ignored channel
      push_beat(200, 4, 0);                 // anchor with only a score
      push_beat(7, 100, 1);                 // out-of-range channel ends frame
      push_beat(0, 4, 1);                   // score at threshold: empty frame
      drain();
      write_reg(RegChannelCount, 16'd6);
      write_reg(RegOverlapThreshold, 16'd0);
      push_beat(320, 0, 0); push_beat(320, 1, 0); push_beat(160, 2, 0);
      push_beat(160, 3, 0); push_beat(9000, 4, 0); push_beat(9000, 5, 0);
      push_beat(320, 0, 0); push_beat(320, 1, 0); push_beat(0, 2, 0);
      push_beat(0, 3, 0); push_beat(9000, 5, 1);
      drain();

      // Random frames; one frame overflows the store under a long receiver hold.
      for (f = 0; f < 14; f++) begin
         case (f % 4)
            0: cc = 5;
            1: cc = 6;
            2: cc = 8;
            default: cc = $urandom_range(5, 12);
         endcase
         if (f == 7) cc = 5;
         write_reg(RegChannelCount, (f == 13) ? 16'd255 : 16'(cc));
         if (f == 13) cc = 128;
         write_reg(RegScoreThreshold, (f % 5 == 0) ? 16'h7FFF :
                   ((f == 7 || $urandom_range(0, 1) == 1) ? 16'd0 :
                    16'($urandom_range(0, 32767))));
         write_reg(RegOverlapThreshold, (f == 7) ? 16'd32768 :
                   ((f % 3 == 0) ? 16'($urandom_range(0, 65535)) :
                    ((f % 3 == 1) ? 16'd0 : 16'd32768)));
         na = (f == 7) ? 72 : ((f == 13) ? 1 : $urandom_range(1, 3));
         if (f == 7) begin
            hold_arm = 1;
            for (a = 0; a < na; a++) begin
               push_beat($urandom_range(16, 1600), 2, 0);
               push_beat($urandom_range(16, 1600), 3, 0);
               push_beat($urandom_range(1, 32767), 4, a == na - 1);
            end
            for (a = 0; a < 6; a++) push_anchor(cc, 1, a == 5);
         end else if (f == 13) begin
            push_beat($urandom_range(0, 65535), 0, 0);
            push_beat($urandom_range(0, 65535), 1, 0);
            push_beat($urandom_range(0, 65535), 2, 0);
            push_beat($urandom_range(0, 65535), 3, 0);
            push_beat($urandom_range(0, 32767), 4, 0);
            push_beat($urandom_range(0, 32767), 120, 0);
            push_beat($urandom_range(0, 32767), 127, 1);
         end else begin
            for (a = 0; a < na; a++) push_anchor(cc, f % 2, a == na - 1);
         end
         drain();
      end

      $display("Covered %0d frames and %0d detections across register settings,",
               frames, dets_seen);
      $display("including store overflow, empty frames and a long receiver stall.");
      if (errors == 0 && expected_dets.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
